// ===== src/asa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asa_pkg
// Shared types and constants for the aligned stack allocator: the payload
// structs of both channels, command and error codes, and the controller
// command group.
// ----------------------------------------------------------------------------
package asa_pkg;

  localparam int unsigned ADDR_W  = 32;
  localparam int unsigned ALIGN_W = 9;
  localparam int unsigned ERR_W   = 3;
  localparam int unsigned CFG_IDX_W = 1;

  // Largest legal alignment in bytes.
  localparam logic [ALIGN_W-1:0] MAX_ALIGN = 9'd256;

  // Request commands.
  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_REGION_BASE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_REGION_END  = 1'b1;

  // Reset value of the region end register.
  localparam logic [ADDR_W-1:0] REGION_END_RESET = 32'h0001_0000;

  // Result error codes.
  localparam logic [ERR_W-1:0] ERR_OK      = 3'd0;
  localparam logic [ERR_W-1:0] ERR_ALIGN   = 3'd1;
  localparam logic [ERR_W-1:0] ERR_SPACE   = 3'd2;
  localparam logic [ERR_W-1:0] ERR_FULL    = 3'd3;
  localparam logic [ERR_W-1:0] ERR_NULL    = 3'd4;
  localparam logic [ERR_W-1:0] ERR_NOT_TOP = 3'd5;
  localparam logic [ERR_W-1:0] ERR_EMPTY   = 3'd6;

  typedef struct packed {
    logic               command;
    logic [ADDR_W-1:0]  request_bytes;
    logic [ALIGN_W-1:0] alignment;
    logic [ADDR_W-1:0]  free_address;
  } in_item_t;

  typedef struct packed {
    logic [ADDR_W-1:0] result_address;
    logic [ERR_W-1:0]  error_code;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;  // latch the accepted request
    logic commit;   // evaluate, update the stack and load the result register
  } ctrl_cmd_t;

endpackage

// ===== src/asa_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asa_ctrl
// Controller for the aligned stack allocator. Takes one request at a time,
// lets the datapath read the stack top in the accept cycle and commits when the
// result register is free.
// ----------------------------------------------------------------------------
module asa_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output asa_pkg::ctrl_cmd_t cmd
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  // The result register can take a new result when it is empty or drained now.
  assign out_free = !out_valid_r || !out_stall;

  assign in_stall    = (state_r != ST_IDLE);
  assign cmd.capture = (state_r == ST_IDLE) && in_valid;
  assign cmd.commit  = (state_r == ST_EXEC) && out_free;
  assign out_valid   = out_valid_r;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Result valid flag: set on commit, cleared after the transfer.
  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (cmd.commit) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== src/asa_dpath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asa_dpath
// Datapath for the aligned stack allocator: region registers, the level
// counter, the raw-top and shift memories, the request register, the
// allocate and deallocate arithmetic, and the result register.
// ----------------------------------------------------------------------------
module asa_dpath #(
  parameter int unsigned STACK_DEPTH = 64
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [asa_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [asa_pkg::ADDR_W-1:0]           cfg_wdata,
  input  asa_pkg::in_item_t                    in_data,
  input  asa_pkg::ctrl_cmd_t                   cmd,
  output asa_pkg::out_item_t                   out_data
);

  localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned LW = $clog2(STACK_DEPTH + 1);

  logic [asa_pkg::ADDR_W-1:0]  region_base_r;
  logic [asa_pkg::ADDR_W-1:0]  region_end_r;
  logic [LW-1:0]               level_r, level_nxt;
  asa_pkg::in_item_t           item_r;
  asa_pkg::out_item_t          out_r, out_nxt;

  logic [asa_pkg::ADDR_W-1:0]  top_mem   [STACK_DEPTH];
  logic [asa_pkg::ALIGN_W-1:0] shift_mem [STACK_DEPTH];
  logic [asa_pkg::ADDR_W-1:0]  rd_top_r;
  logic [asa_pkg::ALIGN_W-1:0] rd_shift_r;

  logic [LW-1:0]               level_dec;
  logic [AW-1:0]               rd_idx;
  logic [AW-1:0]               wr_idx;
  logic                        level_zero;
  logic                        level_full;
  logic [asa_pkg::ADDR_W-1:0]  cur_top;
  logic [asa_pkg::ADDR_W:0]    need;
  logic [asa_pkg::ADDR_W-1:0]  raw;
  logic [asa_pkg::ADDR_W-1:0]  align_ext;
  logic [asa_pkg::ADDR_W-1:0]  aligned;
  logic [asa_pkg::ADDR_W-1:0]  shift_diff;
  logic [asa_pkg::ALIGN_W-1:0] shift_new;
  logic [asa_pkg::ALIGN_W-1:0] align_m1;
  logic                        align_ok;
  logic                        space_bad;
  logic [asa_pkg::ADDR_W-1:0]  free_shift;
  logic                        not_top;
  logic                        push;
  logic                        pop;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      region_base_r <= '0;
      region_end_r  <= asa_pkg::REGION_END_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        asa_pkg::REG_REGION_BASE: region_base_r <= cfg_wdata;
        asa_pkg::REG_REGION_END:  region_end_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Request register.
  always_ff @(posedge clk) begin
    if (cmd.capture) item_r <= in_data;
  end

  // Level decode and memory addresses.
  assign level_dec  = level_r - LW'(1);
  assign rd_idx     = level_dec[AW-1:0];
  assign wr_idx     = level_r[AW-1:0];
  assign level_zero = (level_r == '0);
  assign level_full = (level_r == LW'(STACK_DEPTH));

  // The topmost entry is read every cycle; it is registered, so it is valid in the cycle after accept.
  always_ff @(posedge clk) begin
    rd_top_r   <= top_mem[rd_idx];
    rd_shift_r <= shift_mem[rd_idx];
  end

  always_ff @(posedge clk) begin
    if (push) begin
      top_mem[wr_idx]   <= raw;
      shift_mem[wr_idx] <= shift_new;
    end
  end

  // Allocate arithmetic.
  assign cur_top    = level_zero ? region_end_r : rd_top_r;
  assign align_m1   = item_r.alignment - asa_pkg::ALIGN_W'(1);
  assign align_ok   = (item_r.alignment != '0) &&
                      ((item_r.alignment & align_m1) == '0) &&
                      (item_r.alignment <= asa_pkg::MAX_ALIGN);
  assign align_ext  = asa_pkg::ADDR_W'(item_r.alignment);
  assign need       = {1'b0, item_r.request_bytes} + {1'b0, align_ext};
  assign raw        = cur_top - need[asa_pkg::ADDR_W-1:0];
  assign space_bad  = (need > {1'b0, cur_top}) || (raw < region_base_r);
  assign aligned    = (raw + align_ext) & ~asa_pkg::ADDR_W'(align_m1);
  assign shift_diff = aligned - raw;
  assign shift_new  = shift_diff[asa_pkg::ALIGN_W-1:0];

  // Deallocate check against the topmost entry.
  assign free_shift = asa_pkg::ADDR_W'(rd_shift_r);
  assign not_top    = (free_shift > item_r.free_address) ||
                      ((item_r.free_address - free_shift) != rd_top_r);

  // Result and stack update, in the order the errors are checked.
  always_comb begin
    out_nxt   = '0;
    push      = 1'b0;
    pop       = 1'b0;
    level_nxt = level_r;
    if (item_r.command == asa_pkg::CMD_ALLOC) begin
      if (!align_ok)       out_nxt.error_code = asa_pkg::ERR_ALIGN;
      else if (level_full) out_nxt.error_code = asa_pkg::ERR_FULL;
      else if (space_bad)  out_nxt.error_code = asa_pkg::ERR_SPACE;
      else begin
        out_nxt.error_code     = asa_pkg::ERR_OK;
        out_nxt.result_address = aligned;
        push                   = cmd.commit;
      end
    end else begin
      if (item_r.free_address == '0) out_nxt.error_code = asa_pkg::ERR_NULL;
      else if (level_zero)           out_nxt.error_code = asa_pkg::ERR_EMPTY;
      else if (not_top)              out_nxt.error_code = asa_pkg::ERR_NOT_TOP;
      else begin
        out_nxt.error_code = asa_pkg::ERR_OK;
        pop                = cmd.commit;
      end
    end
    if (push) level_nxt = level_r + LW'(1);
    if (pop)  level_nxt = level_dec;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) level_r <= '0;
    else        level_r <= level_nxt;
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.commit) out_r <= out_nxt;
  end

  assign out_data = out_r;

endmodule

// ===== src/aligned_stack_allocator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aligned_stack_allocator
// Downward-growing stack allocator with power-of-two aligned allocation.
// ----------------------------------------------------------------------------
// Each request has an accept cycle, in which the raw top and shift of the
// topmost allocation are read from the stack memories, and an execute
// state, in which the request is checked, the stack is pushed or popped and
// the result is loaded into the output register. The memory read before the
// read-modify-write of the stack top calls for that split; commit waits
// on a stalled result. One request is in the block at a time, and a
// new request is taken while the previous result still waits. There is no
// clearing pass after reset. Configuration writes are taken at any time but
// are meant to occur only while no request is in flight.
module aligned_stack_allocator #(
  parameter int unsigned STACK_DEPTH = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [asa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [asa_pkg::ADDR_W-1:0]    cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  asa_pkg::in_item_t             in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output asa_pkg::out_item_t            out_data
);

  asa_pkg::ctrl_cmd_t cmd;

  // Request sequencing and output handshake.
  asa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // Stack storage and arithmetic.
  asa_dpath #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .cmd       (cmd),
    .out_data  (out_data)
  );

endmodule

// ===== src/asa_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asa_checker
// Port-level checks for the aligned stack allocator, bound to the top level.
// ----------------------------------------------------------------------------
module asa_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input asa_pkg::out_item_t out_data
);

  // A stalled result holds until its transfer.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // After a request transfer the block takes no further request in the next cycle.
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second request taken while one is in flight");

  // Error codes stay within the defined set.
  a_err_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.error_code <= asa_pkg::ERR_EMPTY)
    else $error("undefined error code");

  // A failed request never grants an address.
  a_err_no_addr: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.error_code != asa_pkg::ERR_OK |->
      out_data.result_address == '0)
    else $error("address granted on error");

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result pending after reset");

endmodule

bind aligned_stack_allocator asa_checker u_asa_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// ===== sim/alloc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alloc_checker
// Watches the allocator's channels, keeps its own copy of the region registers
// and the allocation stack, works out the result of every accepted request
// and compares each result transfer, field by field, with the oldest one due.
// ----------------------------------------------------------------------------
module alloc_checker #(
  parameter int unsigned STACK_DEPTH = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [asa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [asa_pkg::ADDR_W-1:0]    cfg_wdata,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  asa_pkg::in_item_t             in_data,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  asa_pkg::out_item_t            out_data,
  output int                            fail_count,
  output int                            waiting,
  output int                            checked,
  output int                            live_count,
  output logic [asa_pkg::ADDR_W-1:0]    top_grant,
  output logic [asa_pkg::ALIGN_W-1:0]   top_shift,
  output logic [6:0]                    codes_seen,
  output int                            peak_depth
);
  import asa_pkg::*;

  // Shadow copy of the region registers and the allocation stack.
  logic [ADDR_W-1:0]  base_reg;
  logic [ADDR_W-1:0]  end_reg;
  logic [ADDR_W-1:0]  raw_mem [STACK_DEPTH];
  logic [ALIGN_W-1:0] shift_mem [STACK_DEPTH];
  int                 depth;
  int                 peak;
  logic [6:0]         seen_codes;
  out_item_t          due_results [$];
  out_item_t          granted;
  out_item_t          due;

  // Applies one request to the shadow stack and returns the result it earns.
  task automatic apply_request(input in_item_t req, output out_item_t res);
    logic [63:0] cur_top;
    logic [63:0] align;
    logic [63:0] need;
    logic [63:0] raw;
    logic [63:0] aligned;
    logic [63:0] gap;
    logic [63:0] addr;
    logic [63:0] shift;
    res.result_address = '0;
    res.error_code     = ERR_OK;
    if (depth == 0) begin
      cur_top = {32'd0, end_reg};
    end else begin
      cur_top = {32'd0, raw_mem[depth-1]};
    end
    if (req.command == CMD_ALLOC) begin
      align = {55'd0, req.alignment};
      if (align == 64'd0 || (align & (align - 64'd1)) != 64'd0 ||
          align > {55'd0, MAX_ALIGN}) begin
        res.error_code = ERR_ALIGN;
      end else if (depth >= STACK_DEPTH) begin
        res.error_code = ERR_FULL;
      end else begin
        // The subtraction must neither wrap nor drop below the region base.
        need = {32'd0, req.request_bytes} + align;
        if (need > cur_top || cur_top - need < {32'd0, base_reg}) begin
          res.error_code = ERR_SPACE;
        end else begin
          // An already aligned raw address still moves up a full step.
          raw     = cur_top - need;
          aligned = (raw + align) & ~(align - 64'd1);
          gap     = aligned - raw;
          raw_mem[depth]   = raw[ADDR_W-1:0];
          shift_mem[depth] = gap[ALIGN_W-1:0];
          depth++;
          res.result_address = aligned[ADDR_W-1:0];
        end
      end
    end else begin
      addr = {32'd0, req.free_address};
      if (addr == 64'd0) begin
        res.error_code = ERR_NULL;
      end else if (depth == 0) begin
        res.error_code = ERR_EMPTY;
      end else begin
        shift = {55'd0, shift_mem[depth-1]};
        if (shift > addr || addr - shift != cur_top) begin
          res.error_code = ERR_NOT_TOP;
        end else begin
          depth--;
        end
      end
    end
  endtask

  // Results are checked before new requests are taken, so a result can
  // never be matched against a request accepted at the same edge.
  always @(posedge clk) begin
    if (!rst_n) begin
      base_reg   = '0;
      end_reg    = REGION_END_RESET;
      depth      = 0;
      peak       = 0;
      seen_codes = '0;
      due_results.delete();
    end else begin
      if (out_valid && !out_stall) begin
        checked++;
        if (due_results.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("unexpected result %0d: address %h code %0d", checked,
                     out_data.result_address, out_data.error_code);
          end
        end else begin
          due = due_results.pop_front();
          if (out_data.result_address !== due.result_address ||
              out_data.error_code !== due.error_code) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("result %0d mismatch: expected address %h code %0d, got address %h code %0d",
                       checked, due.result_address, due.error_code,
                       out_data.result_address, out_data.error_code);
            end
          end
        end
      end

      // Register writes are applied as they come; the user must keep them to times when the block is idle.
      if (cfg_we) begin
        if (cfg_index == REG_REGION_BASE) begin
          base_reg = cfg_wdata;
        end else if (cfg_index == REG_REGION_END) begin
          end_reg = cfg_wdata;
        end
      end

      if (in_valid && !in_stall) begin
        apply_request(in_data, granted);
        due_results.push_back(granted);
        seen_codes[granted.error_code] = 1'b1;
        if (depth > peak) begin
          peak = depth;
        end
      end
    end

    // Registered view for the stimulus side, stable until the next edge.
    waiting    <= due_results.size();
    live_count <= depth;
    codes_seen <= seen_codes;
    peak_depth <= peak;
    if (depth == 0) begin
      top_grant <= '0;
      top_shift <= '0;
    end else begin
      top_grant <= raw_mem[depth-1] + {{(ADDR_W-ALIGN_W){1'b0}}, shift_mem[depth-1]};
      top_shift <= shift_mem[depth-1];
    end
  end

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the aligned stack allocator. A short directed run
// covers the error codes and boundary fits, then random allocate and release
// sequences run under a series of region settings, with bursty requests and
// a result stall that changes its pattern. The checker does all comparison.
// ----------------------------------------------------------------------------
module tb;
  import asa_pkg::*;

  localparam int unsigned STACK_DEPTH = 64;
  localparam int          CYCLE_LIMIT = 400000;
  localparam int          PHASE_ITEMS = 110;

  typedef enum logic [1:0] {STALL_NONE, STALL_LIGHT, STALL_HALF, STALL_HEAVY} stall_e;
  typedef enum logic [1:0] {MODE_FILL, MODE_DRAIN, MODE_MIXED} mode_e;
  typedef enum logic [1:0] {REQ_ALLOC, REQ_BAD_ALIGN, REQ_FREE_TOP, REQ_FREE_NOISE} req_kind_e;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_REGION_BASE;
  logic [ADDR_W-1:0]    cfg_wdata = '0;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  in_item_t             in_data   = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_item_t            out_data;

  int                   fail_count;
  int                   waiting;
  int                   checked;
  int                   live_count;
  int                   peak_depth;
  logic [ADDR_W-1:0]    top_grant;
  logic [ALIGN_W-1:0]   top_shift;
  logic [6:0]           codes_seen;

  int                   cycles     = 0;
  int                   sent       = 0;
  int                   settings   = 1;
  int                   stall_left = 0;
  stall_e               stall_mode = STALL_NONE;

  aligned_stack_allocator #(.STACK_DEPTH(STACK_DEPTH)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  alloc_checker #(.STACK_DEPTH(STACK_DEPTH)) chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .fail_count(fail_count),
    .waiting   (waiting),
    .checked   (checked),
    .live_count(live_count),
    .top_grant (top_grant),
    .top_shift (top_shift),
    .codes_seen(codes_seen),
    .peak_depth(peak_depth)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Result stall: a new pattern whenever the countdown runs out, from none to heavy.
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= stall_e'($urandom_range(0, 3));
      stall_left <= $urandom_range(8, 60);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      STALL_NONE:  out_stall <= 1'b0;
      STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
      STALL_HALF:  out_stall <= ($urandom_range(0, 1) == 0);
      default:     out_stall <= ($urandom_range(0, 4) != 0);
    endcase
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("run stopped after %0d cycles without finishing", cycles);
      $display("status: fail");
      $finish;
    end
  end

  function automatic in_item_t req(input logic cmd, input logic [ADDR_W-1:0] bytes,
                                   input logic [ALIGN_W-1:0] align,
                                   input logic [ADDR_W-1:0] addr);
    in_item_t r;
    r.command       = cmd;
    r.request_bytes = bytes;
    r.alignment     = align;
    r.free_address  = addr;
    return r;
  endfunction

  // Builds a request of the given kind; unused fields carry random bits.
  // Releases use the checker's view of the topmost allocation.
  function automatic in_item_t make_request(input req_kind_e kind);
    in_item_t    r;
    logic [31:0] noise;
    noise           = $urandom;
    r.command       = CMD_ALLOC;
    r.request_bytes = $urandom;
    r.alignment     = noise[ALIGN_W-1:0];
    r.free_address  = $urandom;
    case (kind)
      REQ_ALLOC: begin
        r.alignment = 9'd1 << $urandom_range(0, 8);
        case ($urandom_range(0, 9))
          0:       ;
          1, 2:    r.request_bytes = $urandom_range(0, 8192);
          default: r.request_bytes = $urandom_range(0, 600);
        endcase
      end
      REQ_BAD_ALIGN: begin
        // Zero or anything that is not a power of two.
        while (r.alignment != '0 && (r.alignment & (r.alignment - 9'd1)) == '0) begin
          noise       = $urandom;
          r.alignment = noise[ALIGN_W-1:0];
        end
      end
      REQ_FREE_TOP: begin
        r.command      = CMD_FREE;
        r.free_address = top_grant;
      end
      default: begin
        r.command = CMD_FREE;
        case ($urandom_range(0, 3))
          0:       r.free_address = '0;
          1:       r.free_address = top_grant ^ (32'd1 << $urandom_range(0, 31));
          2:       r.free_address = top_grant - {23'd0, top_shift};
          default: ;
        endcase
      end
    endcase
    return r;
  endfunction

  function automatic req_kind_e pick_kind(input mode_e mode);
    int roll;
    roll = $urandom_range(0, 99);
    case (mode)
      MODE_FILL:  return roll < 85 ? REQ_ALLOC : (roll < 90 ? REQ_BAD_ALIGN : REQ_FREE_NOISE);
      MODE_DRAIN: return roll < 80 ? REQ_FREE_TOP : (roll < 90 ? REQ_FREE_NOISE : REQ_ALLOC);
      default:    return roll < 45 ? REQ_ALLOC : (roll < 80 ? REQ_FREE_TOP :
                         (roll < 88 ? REQ_BAD_ALIGN : REQ_FREE_NOISE));
    endcase
  endfunction

  // Presents one request and returns at the edge that accepts it.
  task automatic send(input in_item_t item);
    in_data  <= item;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    sent++;
  endtask

  // One request with the channel idle afterwards, so the checker view is current.
  task automatic poke(input in_item_t item);
    send(item);
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Waits until every due result has arrived, then lets the block settle.
  task automatic wait_idle();
    do @(posedge clk); while (waiting != 0);
    repeat (4) @(posedge clk);
  endtask

  // Releases every live allocation, newest first.
  task automatic unwind();
    while (live_count != 0) begin
      poke(make_request(REQ_FREE_TOP));
    end
  endtask

  task automatic load_region(input logic [ADDR_W-1:0] region_lo,
                             input logic [ADDR_W-1:0] region_hi);
    cfg_we    <= 1'b1;
    cfg_index <= REG_REGION_BASE;
    cfg_wdata <= region_lo;
    @(posedge clk);
    cfg_index <= REG_REGION_END;
    cfg_wdata <= region_hi;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    settings++;
  endtask

  // Bursts of requests; the mix shifts between filling, draining and mixed.
  task automatic run_random(input int count, input int fill_len);
    int        done;
    int        burst;
    int        gap;
    int        mode_left;
    mode_e     mode;
    req_kind_e kind;
    done      = 0;
    mode      = MODE_FILL;
    mode_left = fill_len;
    while (done < count) begin
      burst = $urandom_range(1, 16);
      repeat (burst) begin
        if (mode_left == 0) begin
          mode      = mode_e'($urandom_range(0, 2));
          mode_left = $urandom_range(10, 60);
        end
        mode_left--;
        kind = pick_kind(mode);
        // A release of the top needs the previous transfer reflected first.
        if (kind == REQ_FREE_TOP && in_valid) begin
          in_valid <= 1'b0;
          @(posedge clk);
        end
        send(make_request(kind));
        done++;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    if (in_valid) begin
      in_valid <= 1'b0;
    end
  endtask

  initial begin
    logic [ADDR_W-1:0] region_lo;
    logic [ADDR_W-1:0] region_hi;
    logic [ADDR_W-1:0] raw_top;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part under the reset region: error order, odd alignments,
    // boundary fits and releases of the top and of the wrong address.
    poke(req(CMD_FREE, '0, '0, 32'h0000_0100));
    poke(req(CMD_FREE, '1, '1, '0));
    poke(req(CMD_ALLOC, '0, 9'd1, '0));
    poke(req(CMD_ALLOC, 32'd100, MAX_ALIGN, '1));
    poke(req(CMD_ALLOC, 32'd4, 9'd0, '0));
    poke(req(CMD_ALLOC, 32'd4, 9'd3, '0));
    poke(req(CMD_ALLOC, 32'd4, 9'h1ff, '0));
    poke(req(CMD_ALLOC, 32'd4, 9'h180, '0));
    poke(req(CMD_ALLOC, '1, MAX_ALIGN, '0));
    poke(req(CMD_ALLOC, '1, 9'd1, '0));
    poke(req(CMD_FREE, '0, '0, top_grant ^ 32'd1));
    poke(req(CMD_FREE, '0, '0, top_grant - {23'd0, top_shift}));
    poke(req(CMD_FREE, '0, '0, top_grant));
    for (int k = 1; k < 8; k++) begin
      poke(req(CMD_ALLOC, 32'(k * 37), 9'd1 << k, '0));
    end
    // One byte too many, then an exact fit down to the region base.
    raw_top = top_grant - {23'd0, top_shift};
    poke(req(CMD_ALLOC, raw_top - 32'd15, 9'd16, '0));
    poke(req(CMD_ALLOC, raw_top - 32'd16, 9'd16, '0));
    poke(req(CMD_FREE, '0, '0, top_grant));
    poke(req(CMD_FREE, '0, '0, '1));
    poke(req(CMD_FREE, '0, '0, 32'd1));

    run_random(PHASE_ITEMS, 30);

    // Later settings keep whatever allocations are still live, except where
    // the stack is first unwound to start from the region end.
    for (int p = 0; p < 8; p++) begin
      wait_idle();
      if (p == 1 || p == 2 || p == 6) begin
        unwind();
        wait_idle();
      end
      case (p)
        0: begin region_lo = 32'h0000_1000; region_hi = 32'h0002_0000; end
        1: begin region_lo = 32'h0000_0000; region_hi = 32'hffff_ffff; end
        2: begin region_lo = 32'hffff_0000; region_hi = 32'hffff_ffff; end
        3: begin region_lo = 32'h8000_0000; region_hi = 32'h0000_1000; end
        4: begin region_lo = 32'h0000_0000; region_hi = 32'h0000_0000; end
        5: begin region_lo = 32'hffff_ffff; region_hi = 32'hffff_ffff; end
        6: begin
          region_lo = $urandom;
          region_hi = region_lo + $urandom_range(0, 1 << 20);
        end
        default: begin region_lo = '0; region_hi = REGION_END_RESET; end
      endcase
      load_region(region_lo, region_hi);
      run_random(PHASE_ITEMS, (p == 1) ? 100 : $urandom_range(10, 60));
    end

    wait_idle();
    $display("covered %0d requests under %0d region settings, %0d results compared",
             sent, settings, checked);
    $display("error codes returned (one bit per code): %b, deepest stack %0d of %0d",
             codes_seen, peak_depth, STACK_DEPTH);
    if (fail_count == 0 && waiting == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== aligned_stack_allocator.f =====
src/asa_pkg.sv
src/asa_ctrl.sv
src/asa_dpath.sv
src/aligned_stack_allocator.sv
src/asa_checker.sv
sim/alloc_checker.sv
sim/tb.sv
